>>> src/hnl_pkg.sv
package hnl_pkg;

  localparam int NOTE_W = 7;
  localparam int VEL_W  = 16;
  localparam int SIZE_W = 5;
  localparam int CMD_W  = 3;
  localparam int KIND_W = 2;
  localparam int TICK_W = 8;

  localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ALL_OFF = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_HOLD    = 3'd4;

  localparam logic [KIND_W-1:0] EV_LIST = 2'd0;
  localparam logic [KIND_W-1:0] EV_HOLD = 2'd1;
  localparam logic [KIND_W-1:0] EV_DROP = 2'd2;

  localparam logic [TICK_W-1:0] DELAY_RESET = 8'd8;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic              rel;
  } entry_t;

  typedef struct packed {
    logic step;
    logic take_head;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SIZE_W-1:0] prev;
    logic [SIZE_W-1:0] after;
  } res_t;

endpackage

>>> src/hnl_cell.sv
module hnl_cell
  import hnl_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    nb,
  input  entry_t    hd,
  input  entry_t    ap,
  output entry_t    q
);

  // On a step every cell takes its right neighbor, except the one that
  // receives the entry leaving the head.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= ap;
    end else if (ctl.step) begin
      q <= ctl.take_head ? hd : nb;
    end
  end

endmodule

>>> src/held_note_list_with_latch_top.sv
// Each command keeps busy high through one pass over the list and the finish
// state, plus the emit state when it gives two results; count is the list size.
// The time is set by one rotation of the entry chain, one entry per cycle.
// The first result is registered in the finish state, a second in the emit state.
// Synchronous rst empties the list, stops the countdown, turns hold off and
// sets the collect delay to 8; the entry cells themselves are not cleared.
module held_note_list_with_latch_top
  import hnl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [NOTE_W-1:0] note_number,
  input  logic [VEL_W-1:0]  note_velocity,
  input  logic              hold_request,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_wdata,
  output logic              result_valid,
  output logic [KIND_W-1:0] event_kind,
  output logic [SIZE_W-1:0] size_before,
  output logic [SIZE_W-1:0] size_after,
  output logic              hold_state,
  output logic              last_result
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PASS   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [1:0] ST_EMIT2  = 2'd3;

  function automatic logic [SIZE_W-1:0] sz(input logic [CW-1:0] v);
    return SIZE_W'(v);
  endfunction

  logic [1:0]        state;
  logic [CMD_W-1:0]  cmd_q;
  logic [NOTE_W-1:0] note_q;
  logic [VEL_W-1:0]  vel_q;
  logic              req_q;
  logic [CW-1:0]     count;
  logic [TICK_W-1:0] countdown;
  logic              hold;
  logic [TICK_W-1:0] delay;
  logic [CW-1:0]     rem;
  logic [CW-1:0]     kept;
  logic [IW-1:0]     tail;
  logic              found;
  logic              all_rel;
  res_t              pend;

  entry_t    cells [CAPACITY];
  entry_t    head_mod;
  entry_t    app_entry;
  logic      pass_step;
  logic      match;
  logic      keep;
  logic      purge;

  // Completion of a command.
  logic [CW-1:0]     count_next;
  logic [TICK_W-1:0] cd_next;
  logic              hold_next;
  logic [CW-1:0]     base;
  logic              app_ld;
  res_t              res_a;
  res_t              res_b;
  logic              a_v;
  logic              b_v;

  assign busy      = (state != ST_IDLE);
  assign pass_step = (state == ST_PASS) && (rem != '0);
  assign purge     = (cmd_q == CMD_HOLD) && hold && !req_q;
  assign match     = (cells[0].note == note_q) && !found;

  always_comb begin
    head_mod = cells[0];
    keep     = 1'b1;
    if ((cmd_q == CMD_ADD) && match) begin
      head_mod.vel = vel_q;
    end
    if ((cmd_q == CMD_REMOVE) && match) begin
      if (hold) begin
        head_mod.rel = 1'b1;
      end else begin
        keep = 1'b0;
      end
    end
    if ((cmd_q == CMD_ALL_OFF) && hold) begin
      head_mod.rel = 1'b1;
    end
    if (purge && cells[0].rel) begin
      keep = 1'b0;
    end
  end

  assign app_entry = '{note: note_q, vel: vel_q, rel: 1'b0};

  always_comb begin
    count_next = count;
    cd_next    = countdown;
    hold_next  = hold;
    base       = count;
    app_ld     = 1'b0;
    res_a      = '{kind: EV_LIST, prev: sz(count), after: '0};
    res_b      = '{kind: EV_LIST, prev: sz(count), after: sz(count)};
    a_v        = 1'b0;
    b_v        = 1'b0;
    unique case (cmd_q)
      CMD_ADD: begin
        if (hold && all_rel) begin
          a_v  = 1'b1;
          base = '0;
        end
        res_b = '{kind: EV_LIST, prev: sz(base), after: sz(base)};
        if (found && !(hold && all_rel)) begin
          b_v = 1'b1;
        end else if (base >= CW'(CAPACITY)) begin
          b_v        = 1'b1;
          res_b.kind = EV_DROP;
        end else begin
          app_ld     = 1'b1;
          count_next = base + CW'(1);
          if ((base == '0) || (countdown != '0)) begin
            cd_next = delay;
          end
          res_b.after = sz(base + CW'(1));
          b_v         = (cd_next == '0);
        end
      end
      CMD_REMOVE: begin
        count_next = kept;
        res_b      = '{kind: EV_LIST, prev: sz(count), after: sz(kept)};
        b_v        = found && !hold;
      end
      CMD_ALL_OFF: begin
        count_next = hold ? count : '0;
      end
      CMD_TICK: begin
        if (countdown != '0) begin
          cd_next = countdown - TICK_W'(1);
          res_b   = '{kind: EV_LIST, prev: '0, after: sz(count)};
          b_v     = (cd_next == '0) && (count != '0);
        end
      end
      CMD_HOLD: begin
        if (req_q != hold) begin
          hold_next = req_q;
          if (purge) begin
            count_next = kept;
          end
          res_a = '{kind: EV_LIST, prev: sz(count), after: sz(kept)};
          a_v   = purge && (kept != count);
          res_b = '{kind: EV_HOLD, prev: sz(count_next), after: sz(count_next)};
          b_v   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      cell_ctl_t ctl;
      entry_t    nb;
      assign ctl.step      = pass_step;
      assign ctl.take_head = (gi == CAPACITY - 1) || (keep && (tail == IW'(gi)));
      assign ctl.load      = (state == ST_FINISH) && app_ld && (base == CW'(gi));
      if (gi == CAPACITY - 1) begin : g_last
        assign nb = head_mod;
      end else begin : g_mid
        assign nb = cells[gi+1];
      end
      hnl_cell u_cell (
        .clk (clk),
        .ctl (ctl),
        .nb  (nb),
        .hd  (head_mod),
        .ap  (app_entry),
        .q   (cells[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      countdown    <= '0;
      hold         <= 1'b0;
      delay        <= DELAY_RESET;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_we) begin
        delay <= cfg_wdata;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_PASS;
          end
        end
        ST_PASS: begin
          if (rem == '0) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          count     <= count_next;
          countdown <= cd_next;
          hold      <= hold_next;
          result_valid <= a_v || b_v;
          state <= (a_v && b_v) ? ST_EMIT2 : ST_IDLE;
        end
        ST_EMIT2: begin
          result_valid <= 1'b1;
          state        <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The scan registers and the result payload need no reset.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      cmd_q   <= cmd;
      note_q  <= note_number;
      vel_q   <= note_velocity;
      req_q   <= hold_request;
      rem     <= count;
      kept    <= '0;
      tail    <= IW'(count - CW'(1));
      found   <= 1'b0;
      all_rel <= 1'b1;
    end
    if (pass_step) begin
      rem     <= rem - CW'(1);
      kept    <= kept + CW'(keep);
      found   <= found || match;
      all_rel <= all_rel && cells[0].rel;
      if (!keep) begin
        tail <= tail - IW'(1);
      end
    end
    if (state == ST_FINISH) begin
      event_kind  <= a_v ? res_a.kind : res_b.kind;
      size_before <= a_v ? res_a.prev : res_b.prev;
      size_after  <= a_v ? res_a.after : res_b.after;
      hold_state  <= hold_next;
      last_result <= !(a_v && b_v);
      pend        <= res_b;
    end
    if (state == ST_EMIT2) begin
      event_kind  <= pend.kind;
      size_before <= pend.prev;
      size_after  <= pend.after;
      hold_state  <= hold;
      last_result <= 1'b1;
    end
  end

`ifndef SYNTH
  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == ST_FINISH || state == ST_EMIT2))
    else $error("result strobe without a finishing command");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command transfer did not raise busy");

  a_second_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT2) |=> (result_valid && last_result))
    else $error("second result missing or not marked last");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |=> (count <= CW'(CAPACITY)))
    else $error("list size above capacity");
`endif

endmodule
